// ----- rtl/hrpd_pkg.sv -----
`default_nettype none
package hrpd_pkg;

   localparam int BYTE_W     = 8;
   localparam int TIME_W     = 16;
   localparam int VALUE1_W   = 25;
   localparam int VALUE2_W   = 16;
   localparam int VALUE3_W   = 8;
   localparam int PAGE_W     = 7;
   localparam int RR_SCALE_W = 10;
   localparam int RR_SHIFT   = 10;
   localparam int RR_PROD_W  = TIME_W + RR_SCALE_W;

   localparam logic [BYTE_W-1:0]     LIMIT_RESET = 8'd64;
   localparam logic [RR_SCALE_W-1:0] RR_SCALE    = 10'd1000;

   localparam logic [PAGE_W-1:0] PAGE_DEFAULT      = 7'd0;
   localparam logic [PAGE_W-1:0] PAGE_OP_TIME      = 7'd1;
   localparam logic [PAGE_W-1:0] PAGE_MANUFACTURER = 7'd2;
   localparam logic [PAGE_W-1:0] PAGE_VERSION      = 7'd3;
   localparam logic [PAGE_W-1:0] PAGE_PREV_BEAT    = 7'd4;

   typedef enum logic [1:0] {
      SENDER_UNKNOWN = 2'd0,
      SENDER_LEGACY  = 2'd1,
      SENDER_CURRENT = 2'd2
   } sender_kind_type;

   typedef enum logic [2:0] {
      PK_LEGACY     = 3'd0,
      PK_PAGE0      = 3'd1,
      PK_OP_TIME    = 3'd2,
      PK_MAKER      = 3'd3,
      PK_VERSION    = 3'd4,
      PK_RR         = 3'd5,
      PK_RR_SKIPPED = 3'd6,
      PK_UNKNOWN    = 3'd7
   } page_kind_type;

   typedef struct packed {
      logic            produce;
      sender_kind_type kind;
   } detect_status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] page_byte;
      logic [BYTE_W-1:0] payload_byte1;
      logic [BYTE_W-1:0] payload_byte2;
      logic [BYTE_W-1:0] payload_byte3;
      logic [BYTE_W-1:0] time_low_byte;
      logic [BYTE_W-1:0] time_high_byte;
      logic [BYTE_W-1:0] beat_counter_byte;
      logic [BYTE_W-1:0] rate_byte;
   } req_fields_type;

   typedef struct packed {
      logic                device_kind;
      page_kind_type       page_kind;
      logic [BYTE_W-1:0]   heart_rate;
      logic [BYTE_W-1:0]   beat_count;
      logic [TIME_W-1:0]   event_time;
      logic [VALUE1_W-1:0] first_value;
      logic [VALUE2_W-1:0] second_value;
      logic [VALUE3_W-1:0] third_value;
   } rsp_fields_type;

endpackage
`default_nettype wire

// ----- rtl/hrpd_req_if.sv -----
`default_nettype none
interface hrpd_req_if;
   import hrpd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] page_byte;
   logic [BYTE_W-1:0] payload_byte1;
   logic [BYTE_W-1:0] payload_byte2;
   logic [BYTE_W-1:0] payload_byte3;
   logic [BYTE_W-1:0] time_low_byte;
   logic [BYTE_W-1:0] time_high_byte;
   logic [BYTE_W-1:0] beat_counter_byte;
   logic [BYTE_W-1:0] rate_byte;

   modport source (
      output valid, page_byte, payload_byte1, payload_byte2, payload_byte3,
             time_low_byte, time_high_byte, beat_counter_byte, rate_byte,
      input  ready
   );

   modport sink (
      input  valid, page_byte, payload_byte1, payload_byte2, payload_byte3,
             time_low_byte, time_high_byte, beat_counter_byte, rate_byte,
      output ready
   );

endinterface
`default_nettype wire

// ----- rtl/hrpd_rsp_if.sv -----
`default_nettype none
interface hrpd_rsp_if;
   import hrpd_pkg::*;

   logic                valid;
   logic                ready;
   logic                device_kind;
   logic [2:0]          page_kind;
   logic [BYTE_W-1:0]   heart_rate;
   logic [BYTE_W-1:0]   beat_count;
   logic [TIME_W-1:0]   event_time;
   logic [VALUE1_W-1:0] first_value;
   logic [VALUE2_W-1:0] second_value;
   logic [VALUE3_W-1:0] third_value;

   modport source (
      output valid, device_kind, page_kind, heart_rate, beat_count, event_time,
             first_value, second_value, third_value,
      input  ready
   );

   modport sink (
      input  valid, device_kind, page_kind, heart_rate, beat_count, event_time,
             first_value, second_value, third_value,
      output ready
   );

endinterface
`default_nettype wire

// ----- rtl/hrpd_detect.sv -----
`default_nettype none
module hrpd_detect (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write_enable,
   input  wire logic [hrpd_pkg::BYTE_W-1:0] csr_write_data,
   input  wire logic                        fire,
   input  wire logic                        toggle_bit,
   output hrpd_pkg::detect_status_type      status
);
   import hrpd_pkg::*;

   logic [BYTE_W-1:0] limit_ff;
   logic [BYTE_W-1:0] limit_in;
   sender_kind_type   kind_ff;
   sender_kind_type   kind_in;
   logic              toggle_valid_ff;
   logic              toggle_valid_in;
   logic              toggle_seen_ff;
   logic              toggle_seen_in;
   logic [BYTE_W-1:0] attempt_ff;
   logic [BYTE_W-1:0] attempt_in;

   sender_kind_type   kind_next;
   logic              valid_next;
   logic              seen_next;
   logic [BYTE_W-1:0] attempt_next;

   always_comb begin
      kind_next    = kind_ff;
      valid_next   = toggle_valid_ff;
      seen_next    = toggle_seen_ff;
      attempt_next = attempt_ff;
      if (kind_ff == SENDER_UNKNOWN) begin
         if (attempt_ff < limit_ff) begin
            if (toggle_valid_ff && (toggle_bit != toggle_seen_ff)) begin
               kind_next = SENDER_CURRENT;
            end else begin
               seen_next    = toggle_bit;
               valid_next   = 1'b1;
               attempt_next = attempt_ff + 8'd1;
            end
         end
         if ((attempt_next >= limit_ff) && (kind_next == SENDER_UNKNOWN)) begin
            kind_next = SENDER_LEGACY;
         end
      end
   end

   always_comb begin
      status.kind    = kind_next;
      status.produce = (kind_next != SENDER_UNKNOWN);
   end

   always_comb begin
      limit_in        = csr_write_enable ? csr_write_data : limit_ff;
      kind_in         = fire ? kind_next : kind_ff;
      toggle_valid_in = fire ? valid_next : toggle_valid_ff;
      toggle_seen_in  = fire ? seen_next : toggle_seen_ff;
      attempt_in      = fire ? attempt_next : attempt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff        <= LIMIT_RESET;
         kind_ff         <= SENDER_UNKNOWN;
         toggle_valid_ff <= 1'b0;
         toggle_seen_ff  <= 1'b0;
         attempt_ff      <= '0;
      end else begin
         limit_ff        <= limit_in;
         kind_ff         <= kind_in;
         toggle_valid_ff <= toggle_valid_in;
         toggle_seen_ff  <= toggle_seen_in;
         attempt_ff      <= attempt_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/hrpd_page.sv -----
`default_nettype none
module hrpd_page (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     fire,
   input  wire hrpd_pkg::sender_kind_type kind,
   input  wire hrpd_pkg::req_fields_type  fields,
   output hrpd_pkg::rsp_fields_type      result
);
   import hrpd_pkg::*;

   logic [BYTE_W-1:0]    prev_beat_ff;
   logic [BYTE_W-1:0]    prev_beat_in;
   logic [PAGE_W-1:0]    page;
   logic [TIME_W-1:0]    event_time;
   logic [TIME_W-1:0]    prev_time;
   logic [TIME_W-1:0]    rr_ticks;
   logic [RR_PROD_W-1:0] rr_product;
   logic [BYTE_W-1:0]    beat_delta;
   logic                 is_current;

   assign page       = fields.page_byte[PAGE_W-1:0];
   assign event_time = {fields.time_high_byte, fields.time_low_byte};
   assign prev_time  = {fields.payload_byte3, fields.payload_byte2};
   assign rr_ticks   = event_time - prev_time;
   assign rr_product = RR_PROD_W'(rr_ticks) * RR_PROD_W'(RR_SCALE);
   assign beat_delta = fields.beat_counter_byte - prev_beat_ff;
   assign is_current = (kind == SENDER_CURRENT);

   always_comb begin
      result.device_kind  = is_current;
      result.page_kind    = PK_LEGACY;
      result.heart_rate   = fields.rate_byte;
      result.beat_count   = fields.beat_counter_byte;
      result.event_time   = event_time;
      result.first_value  = '0;
      result.second_value = '0;
      result.third_value  = '0;
      if (is_current) begin
         case (page)
            PAGE_DEFAULT: begin
               result.page_kind = PK_PAGE0;
            end
            PAGE_OP_TIME: begin
               result.page_kind   = PK_OP_TIME;
               result.first_value = {fields.payload_byte3, fields.payload_byte2,
                                     fields.payload_byte1, 1'b0};
            end
            PAGE_MANUFACTURER: begin
               result.page_kind    = PK_MAKER;
               result.first_value  = VALUE1_W'(fields.payload_byte1);
               result.second_value = prev_time;
            end
            PAGE_VERSION: begin
               result.page_kind    = PK_VERSION;
               result.first_value  = VALUE1_W'(fields.payload_byte1);
               result.second_value = VALUE2_W'(fields.payload_byte2);
               result.third_value  = fields.payload_byte3;
            end
            PAGE_PREV_BEAT: begin
               if (beat_delta == 8'd1) begin
                  result.page_kind   = PK_RR;
                  result.first_value = VALUE1_W'(rr_product[RR_PROD_W-1:RR_SHIFT]);
               end else begin
                  result.page_kind = PK_RR_SKIPPED;
               end
            end
            default: begin
               result.page_kind = PK_UNKNOWN;
            end
         endcase
      end
   end

   always_comb begin
      prev_beat_in = prev_beat_ff;
      if (fire && is_current && (page == PAGE_PREV_BEAT)) begin
         prev_beat_in = fields.beat_counter_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_beat_ff <= '0;
      end else begin
         prev_beat_ff <= prev_beat_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/heart_rate_page_decoder.sv -----
// Each request is held in the input register, then its result in the result
// register.
// Throughput: one request per cycle; the input register advances whenever the
// result register is empty or being taken in the same cycle.
// Reset (synchronous): drops both stages, sets the attempt limit to 64 and
// restarts sender detection with no toggle seen and previous beat zero.
`default_nettype none
module heart_rate_page_decoder (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write_enable,
   input  wire logic [hrpd_pkg::BYTE_W-1:0] csr_write_data,
   hrpd_req_if.sink                         req_bus,
   hrpd_rsp_if.source                       rsp_bus
);
   import hrpd_pkg::*;

   logic              req_valid_ff;
   logic              req_valid_in;
   req_fields_type    req_data_ff;
   req_fields_type    req_data_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_fields_type    rsp_data_ff;
   rsp_fields_type    rsp_data_in;

   logic              fire;
   logic              take;
   detect_status_type status;
   rsp_fields_type    result;

   assign fire          = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign take          = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !req_valid_ff || fire;

   hrpd_detect u_detect (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fire             (fire),
      .toggle_bit       (req_data_ff.page_byte[BYTE_W-1]),
      .status           (status)
   );

   hrpd_page u_page (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .kind   (status.kind),
      .fields (req_data_ff),
      .result (result)
   );

   always_comb begin
      req_data_in = req_data_ff;
      if (take) begin
         req_data_in.page_byte         = req_bus.page_byte;
         req_data_in.payload_byte1     = req_bus.payload_byte1;
         req_data_in.payload_byte2     = req_bus.payload_byte2;
         req_data_in.payload_byte3     = req_bus.payload_byte3;
         req_data_in.time_low_byte     = req_bus.time_low_byte;
         req_data_in.time_high_byte    = req_bus.time_high_byte;
         req_data_in.beat_counter_byte = req_bus.beat_counter_byte;
         req_data_in.rate_byte         = req_bus.rate_byte;
      end
      req_valid_in = take || (req_valid_ff && !fire);
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (fire) begin
         rsp_valid_in = status.produce;
         if (status.produce) begin
            rsp_data_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.device_kind  = rsp_data_ff.device_kind;
   assign rsp_bus.page_kind    = rsp_data_ff.page_kind;
   assign rsp_bus.heart_rate   = rsp_data_ff.heart_rate;
   assign rsp_bus.beat_count   = rsp_data_ff.beat_count;
   assign rsp_bus.event_time   = rsp_data_ff.event_time;
   assign rsp_bus.first_value  = rsp_data_ff.first_value;
   assign rsp_bus.second_value = rsp_data_ff.second_value;
   assign rsp_bus.third_value  = rsp_data_ff.third_value;

endmodule
`default_nettype wire

// ----- bench/tb_heart_rate_page_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_heart_rate_page_decoder;
   import hrpd_pkg::*;

   localparam int MS_PER_SECOND    = 1000;
   localparam int TICKS_PER_SECOND = 1024;
   localparam int PIPE_CYCLES      = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic [BYTE_W-1:0] csr_write_data   = '0;

   hrpd_req_if req_link ();
   hrpd_rsp_if rsp_link ();

   heart_rate_page_decoder DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_link),
      .rsp_bus          (rsp_link)
   );

   always #4 clock = ~clock;

   sender_kind_type   sensor_kind;
   bit                toggle_known;
   bit                toggle_level;
   logic [BYTE_W-1:0] attempts_seen;
   logic [BYTE_W-1:0] limit_setting;
   logic [BYTE_W-1:0] last_rr_beat;

   rsp_fields_type decoded_pages[$];
   int error_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;
   int hold_left      = 0;

   logic [BYTE_W-1:0] gen_beat;
   logic [TIME_W-1:0] gen_time;
   logic [TIME_W-1:0] gen_prev_time;

   function automatic bit decode_payload(input req_fields_type p, output rsp_fields_type r);
      logic [TIME_W-1:0] rr_ticks;
      int unsigned       rr_ms;
      r = '0;
      if (sensor_kind == SENDER_UNKNOWN) begin
         if (attempts_seen < limit_setting) begin
            if (toggle_known && p.page_byte[7] != toggle_level) begin
               sensor_kind = SENDER_CURRENT;
            end else begin
               toggle_level  = p.page_byte[7];
               toggle_known  = 1'b1;
               attempts_seen = attempts_seen + 8'd1;
            end
         end
         if (attempts_seen >= limit_setting && sensor_kind == SENDER_UNKNOWN)
            sensor_kind = SENDER_LEGACY;
         if (sensor_kind == SENDER_UNKNOWN)
            return 1'b0;
      end
      r.page_kind  = PK_LEGACY;
      r.heart_rate = p.rate_byte;
      r.beat_count = p.beat_counter_byte;
      r.event_time = {p.time_high_byte, p.time_low_byte};
      if (sensor_kind == SENDER_CURRENT) begin
         r.device_kind = 1'b1;
         case (p.page_byte[PAGE_W-1:0])
            PAGE_DEFAULT: r.page_kind = PK_PAGE0;
            PAGE_OP_TIME: begin
               r.page_kind   = PK_OP_TIME;
               r.first_value = {p.payload_byte3, p.payload_byte2, p.payload_byte1, 1'b0};
            end
            PAGE_MANUFACTURER: begin
               r.page_kind    = PK_MAKER;
               r.first_value  = VALUE1_W'(p.payload_byte1);
               r.second_value = {p.payload_byte3, p.payload_byte2};
            end
            PAGE_VERSION: begin
               r.page_kind    = PK_VERSION;
               r.first_value  = VALUE1_W'(p.payload_byte1);
               r.second_value = VALUE2_W'(p.payload_byte2);
               r.third_value  = p.payload_byte3;
            end
            PAGE_PREV_BEAT: begin
               if (BYTE_W'(p.beat_counter_byte - last_rr_beat) == 8'd1) begin
                  rr_ticks      = r.event_time - {p.payload_byte3, p.payload_byte2};
                  rr_ms         = (int'(rr_ticks) * MS_PER_SECOND) / TICKS_PER_SECOND;
                  r.page_kind   = PK_RR;
                  r.first_value = VALUE1_W'(rr_ms);
               end else begin
                  r.page_kind = PK_RR_SKIPPED;
               end
               last_rr_beat = p.beat_counter_byte;
            end
            default: r.page_kind = PK_UNKNOWN;
         endcase
      end
      return 1'b1;
   endfunction

   function automatic req_fields_type payload_of(input logic [7:0] page, b1, b2, b3,
                                                 input logic [15:0] etime,
                                                 input logic [7:0] beat, rate);
      req_fields_type p;
      p.page_byte         = page;
      p.payload_byte1     = b1;
      p.payload_byte2     = b2;
      p.payload_byte3     = b3;
      p.time_low_byte     = etime[7:0];
      p.time_high_byte    = etime[15:8];
      p.beat_counter_byte = beat;
      p.rate_byte         = rate;
      return p;
   endfunction

   function automatic req_fields_type random_payload();
      req_fields_type p;
      logic [7:0]     page;
      if ($urandom_range(0, 9) < 3)
         return req_fields_type'({$urandom(), $urandom()});
      case ($urandom_range(0, 9))
         0: begin
            gen_beat      = gen_beat + 8'($urandom_range(2, 6));
            gen_prev_time = gen_time;
            gen_time      = gen_time + 16'($urandom_range(300, 1500));
         end
         1, 2, 3, 4: begin
            gen_beat      = gen_beat + 8'd1;
            gen_prev_time = gen_time;
            gen_time      = gen_time + 16'($urandom_range(300, 1500));
         end
         default: ;
      endcase
      page = $urandom_range(0, 1) ? {1'b0, PAGE_PREV_BEAT} : 8'($urandom_range(0, 3));
      page[7] = 1'($urandom_range(0, 1));
      p = payload_of(page, 8'($urandom()), 8'($urandom()), 8'($urandom()), gen_time,
                     gen_beat, 8'($urandom_range(40, 200)));
      if (page[PAGE_W-1:0] == PAGE_PREV_BEAT) begin
         p.payload_byte2 = gen_prev_time[7:0];
         p.payload_byte3 = gen_prev_time[15:8];
      end
      return p;
   endfunction

   function automatic void check_field(input string name, input int unsigned want, got);
      if (want !== got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   task automatic offer_payload(input req_fields_type p);
      rsp_fields_type r;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_link.valid <= 1'b0;
         @(posedge clock);
      end
      req_link.valid             <= 1'b1;
      req_link.page_byte         <= p.page_byte;
      req_link.payload_byte1     <= p.payload_byte1;
      req_link.payload_byte2     <= p.payload_byte2;
      req_link.payload_byte3     <= p.payload_byte3;
      req_link.time_low_byte     <= p.time_low_byte;
      req_link.time_high_byte    <= p.time_high_byte;
      req_link.beat_counter_byte <= p.beat_counter_byte;
      req_link.rate_byte         <= p.rate_byte;
      @(posedge clock);
      while (!req_link.ready) @(posedge clock);
      if (decode_payload(p, r))
         decoded_pages.insert(decoded_pages.size(), r);
   endtask

   task automatic settle_pipeline();
      req_link.valid <= 1'b0;
      while (decoded_pages.size() != 0) @(posedge clock);
      repeat (PIPE_CYCLES) @(posedge clock);
   endtask

   task automatic set_attempt_limit(input logic [BYTE_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      limit_setting = value;
   endtask

   // Receive side: check each transfer, then draw ready for the next cycle.
   initial begin
      rsp_fields_type want;
      rsp_link.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_link.valid && rsp_link.ready) begin
            if (decoded_pages.size() == 0) begin
               $error("result transfer with no expected result pending");
               error_count++;
            end else begin
               want = decoded_pages.pop_front();
               check_field("device_kind", want.device_kind, rsp_link.device_kind);
               check_field("page_kind", want.page_kind, rsp_link.page_kind);
               check_field("heart_rate", want.heart_rate, rsp_link.heart_rate);
               check_field("beat_count", want.beat_count, rsp_link.beat_count);
               check_field("event_time", want.event_time, rsp_link.event_time);
               check_field("first_value", want.first_value, rsp_link.first_value);
               check_field("second_value", want.second_value, rsp_link.second_value);
               check_field("third_value", want.third_value, rsp_link.third_value);
            end
         end
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_link.ready <= 1'b0;
         end else begin
            rsp_link.ready <= !reset && ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   task automatic test_detection();
      req_fields_type p;
      bit             level;
      int             runs;
      level = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0: begin
            // zero limit: first payload settles the sender as legacy
            set_attempt_limit(8'd0);
            offer_payload(random_payload());
         end
         1: begin
            // lower the limit below the attempts already made
            set_attempt_limit(8'd255);
            repeat (5) begin
               p = random_payload();
               p.page_byte[7] = level;
               offer_payload(p);
            end
            settle_pipeline();
            set_attempt_limit(8'd3);
            offer_payload(random_payload());
         end
         2: begin
            // run out the reset limit with a steady toggle
            repeat (LIMIT_RESET) begin
               p = random_payload();
               p.page_byte[7] = level;
               offer_payload(p);
            end
         end
         default: begin
            set_attempt_limit(8'd255);
            runs = $urandom_range(1, 20);
            repeat (runs) begin
               p = random_payload();
               p.page_byte[7] = level;
               offer_payload(p);
            end
            p = random_payload();
            p.page_byte[7] = !level;
            offer_payload(p);
         end
      endcase
      settle_pipeline();
      set_attempt_limit(8'd1);
   endtask

   task automatic test_directed_pages();
      offer_payload(payload_of(8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00));
      offer_payload(payload_of(8'h81, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF));
      offer_payload(payload_of(8'h01, 8'h01, 8'h00, 8'h80, 16'h1234, 8'h01, 8'h3C));
      offer_payload(payload_of(8'h82, 8'hFF, 8'h34, 8'h12, 16'h8000, 8'h02, 8'h50));
      offer_payload(payload_of(8'h02, 8'h00, 8'hFF, 8'hFF, 16'h00FF, 8'h03, 8'h51));
      offer_payload(payload_of(8'h83, 8'h07, 8'h2A, 8'hC3, 16'h0100, 8'h04, 8'h52));
      offer_payload(payload_of(8'h84, 8'h00, 8'h00, 8'h00, 16'h0400, 8'hFF, 8'h60));
      // beat count wraps while the previous time wraps past zero
      offer_payload(payload_of(8'h04, 8'h00, 8'hF0, 8'hFF, 16'h0010, 8'h00, 8'h61));
      offer_payload(payload_of(8'h84, 8'h00, 8'h10, 8'h00, 16'h0400, 8'h00, 8'h62));
      offer_payload(payload_of(8'h04, 8'h00, 8'h00, 8'h04, 16'h0800, 8'h05, 8'h63));
      offer_payload(payload_of(8'h84, 8'hAA, 8'h00, 8'h00, 16'hFFFF, 8'h06, 8'h64));
      offer_payload(payload_of(8'h04, 8'h55, 8'h34, 8'h12, 16'h1234, 8'h07, 8'h65));
      offer_payload(payload_of(8'h04, 8'h00, 8'h01, 8'h00, 16'h0000, 8'h08, 8'h66));
      offer_payload(payload_of(8'h05, 8'h11, 8'h22, 8'h33, 16'h4444, 8'h09, 8'h70));
      offer_payload(payload_of(8'h7F, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'h0A, 8'h71));
      offer_payload(payload_of(8'hFF, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h0B, 8'h72));
      offer_payload(payload_of(8'hC0, 8'h5A, 8'hA5, 8'h5A, 16'hA55A, 8'h0C, 8'h73));
      settle_pipeline();
      set_attempt_limit(8'd255);
   endtask

   task automatic test_random_traffic();
      int idle_pct[4]  = '{0, 48, 0, 18};
      int stall_pct[4] = '{0, 0, 48, 18};
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = idle_pct[phase];
         recv_stall_pct = stall_pct[phase];
         repeat (480) offer_payload(random_payload());
         settle_pipeline();
         set_attempt_limit(8'($urandom_range(0, 255)));
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   task automatic test_backpressure();
      hold_request = 300;
      repeat (40) offer_payload(random_payload());
      settle_pipeline();
      set_attempt_limit(LIMIT_RESET);
   endtask

   initial begin
      int guard;
      sensor_kind   = SENDER_UNKNOWN;
      toggle_known  = 1'b0;
      toggle_level  = 1'b0;
      attempts_seen = '0;
      limit_setting = LIMIT_RESET;
      last_rr_beat  = '0;
      gen_beat      = 8'($urandom());
      gen_time      = 16'($urandom());
      gen_prev_time = gen_time;
      req_link.valid             = 1'b0;
      req_link.page_byte         = '0;
      req_link.payload_byte1     = '0;
      req_link.payload_byte2     = '0;
      req_link.payload_byte3     = '0;
      req_link.time_low_byte     = '0;
      req_link.time_high_byte    = '0;
      req_link.beat_counter_byte = '0;
      req_link.rate_byte         = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_detection();
      test_directed_pages();
      test_random_traffic();
      test_backpressure();

      req_link.valid <= 1'b0;
      guard = 0;
      while (decoded_pages.size() != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (PIPE_CYCLES * 2) @(posedge clock);
      if (decoded_pages.size() != 0) begin
         $error("%0d expected results never arrived", decoded_pages.size());
         error_count++;
      end
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
`default_nettype wire
